[sv/btrd_pkg.sv]
// Shared types, widths and constants for the binary to radix digit converter.
`timescale 1ns / 1ps

package btrd_pkg;

    // Input value width and digit stack depth (base 2 gives one digit per bit).
    localparam int VALUE_BITS = 31;
    localparam int DEPTH      = VALUE_BITS;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Divider retires STEP_BITS quotient bits per cycle.
    localparam int STEP_BITS  = 8;
    localparam int CHUNKS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W      = CHUNKS * STEP_BITS;
    localparam int CHUNK_CW   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    localparam int BASE_W     = 5;
    localparam int DIGIT_W    = 4;

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
    localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(16);

    // Configuration port
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;
    localparam int PIDX_W  = PADDR_W - 2;
    localparam logic [PIDX_W-1:0] REG_BASE = PIDX_W'(0);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [DIGIT_W-1:0]    t_digit;
    typedef logic [BASE_W-1:0]     t_base;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic push;
        logic pop;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_chunk;
        logic quo_zero;
        logic one_left;
    } t_stat;

endpackage

[sv/btrd_in_if.sv]
// Request channel carrying one binary value.
`timescale 1ns / 1ps

interface btrd_in_if;
    import btrd_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[sv/btrd_out_if.sv]
// Result channel carrying one digit and its last flag.
`timescale 1ns / 1ps

interface btrd_out_if;
    import btrd_pkg::*;

    logic   valid;
    logic   ready;
    t_digit digit;
    logic   last;

    modport source (output valid, output digit, output last, input ready);
    modport sink   (input valid, input digit, input last, output ready);
endinterface

[sv/btrd_ctrl.sv]
// Controller state machine: load, divide, push digits, then pop them out.
`timescale 1ns / 1ps

module btrd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  btrd_pkg::t_stat  i_stat,
    output btrd_pkg::t_cmd   o_cmd
);
    import btrd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_ready;
    logic   r_ovalid;

    assign o_in_ready  = r_ready;
    assign o_out_valid = r_ovalid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = (r_state == S_IDLE) && i_in_valid && r_ready;
        o_cmd.step = (r_state == S_DIV);
        o_cmd.push = (r_state == S_PUSH);
        o_cmd.pop  = (r_state == S_EMIT) && r_ovalid && i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ready  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_ready) begin
                        r_ready <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_stat.last_chunk) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    // quotient zero: all digits are stacked
                    if (i_stat.quo_zero) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready && i_stat.one_left) begin
                        r_ovalid <= 1'b0;
                        r_ready  <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_ready  <= 1'b1;
                    r_ovalid <= 1'b0;
                end
            endcase
        end
    end

endmodule

[sv/btrd_dp.sv]
// Datapath: multi-bit-per-cycle divider by the base and a digit stack.
`timescale 1ns / 1ps

module btrd_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  btrd_pkg::t_cmd    i_cmd,
    input  btrd_pkg::t_value  i_value,
    input  btrd_pkg::t_base   i_base,
    output btrd_pkg::t_stat   o_stat,
    output btrd_pkg::t_digit  o_digit,
    output logic              o_last
);
    import btrd_pkg::*;

    logic [DIV_W-1:0]    r_div;
    logic [DIV_W-1:0]    n_div;
    t_digit              r_rem;
    t_digit              n_rem;
    logic [CHUNK_CW-1:0] r_chunk;
    t_digit              r_stack [DEPTH];
    logic [CNT_W-1:0]    r_cnt;

    // Restoring division of the top chunk, remainder carried from r_rem.
    always_comb begin
        logic [BASE_W-1:0]    rem;
        logic [STEP_BITS-1:0] bits;
        logic [STEP_BITS-1:0] q;
        rem  = BASE_W'(r_rem);
        bits = r_div[DIV_W-1 -: STEP_BITS];
        q    = '0;
        for (int i = STEP_BITS - 1; i >= 0; i--) begin
            rem = {rem[BASE_W-2:0], bits[i]};
            if (rem >= i_base) begin
                rem  = rem - i_base;
                q[i] = 1'b1;
            end
        end
        n_rem = rem[DIGIT_W-1:0];
        n_div = (r_div << STEP_BITS) | DIV_W'(q);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_div <= DIV_W'(i_value);
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_div <= n_div;
            r_rem <= n_rem;
        end else if (i_cmd.push) begin
            r_rem <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else if (i_cmd.load || i_cmd.push) begin
            r_chunk <= '0;
        end else if (i_cmd.step) begin
            r_chunk <= r_chunk + CHUNK_CW'(1);
        end
    end

    // Stack: push least significant first, pop from the top gives MSD first.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[0] <= r_rem;
            for (int i = 1; i < DEPTH; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.push) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.last_chunk = (r_chunk == CHUNK_CW'(CHUNKS - 1));
        o_stat.quo_zero   = (r_div == '0);
        o_stat.one_left   = (r_cnt == CNT_W'(1));
    end

    assign o_digit = r_stack[0];
    assign o_last  = o_stat.one_left;

endmodule

[sv/binary_to_radix_digits.sv]
// Top level: binary value to base-N digits, most significant digit first.
//
//   channel  | direction | payload          | handshake
//   ---------+-----------+------------------+----------------------------
//   i_in     | sink      | value[30:0]      | valid / ready
//   o_out    | source    | digit[3:0], last | valid / ready
//   apb      | slave     | base at addr 0   | psel, penable, pwrite
//
// One request at a time. For each digit the shared divider works through
// CHUNKS = ceil(VALUE_BITS / 8) = 4 chunks, retiring 8 quotient bits per
// cycle, then pushes the remainder as a digit; the stacked digits then go out.
// Synchronous active-low reset; base resets to 10.
// A stalled output holds its digit; no new request is taken until the last
// digit has gone out.
`timescale 1ns / 1ps

module binary_to_radix_digits (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    btrd_in_if.sink                        i_in,
    btrd_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [btrd_pkg::PADDR_W-1:0]   paddr,
    input  logic [btrd_pkg::PDATA_W-1:0]   pwdata,
    output logic [btrd_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import btrd_pkg::*;

    t_base r_base;
    t_base eff_base;
    t_cmd  cmd;
    t_stat stat;
    logic  reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_base <= pwdata[BASE_W-1:0];
        end
    end

    assign prdata = reg_hit ? PDATA_W'(r_base) : '0;

    // Saturate the base into 2..16
    always_comb begin
        if (r_base < BASE_MIN) begin
            eff_base = BASE_MIN;
        end else if (r_base > BASE_MAX) begin
            eff_base = BASE_MAX;
        end else begin
            eff_base = r_base;
        end
    end

    btrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    btrd_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_value (i_in.value),
        .i_base  (eff_base),
        .o_stat  (stat),
        .o_digit (o_out.digit),
        .o_last  (o_out.last)
    );

endmodule

[sv/btrd_checker.sv]
// Port-level assertions for the converter and the bind that attaches them.
`timescale 1ns / 1ps

module btrd_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic                   i_out_last,
    input  btrd_pkg::t_digit       i_out_digit
);
    import btrd_pkg::*;

    // No new request while digits are still going out.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while output valid");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after a request");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (i_in_ready && !i_out_valid))
        else $error("not idle after last digit");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_digit) && $stable(i_out_last)))
        else $error("stalled output changed");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("not idle after reset");

endmodule

bind binary_to_radix_digits btrd_checker u_btrd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_last  (o_out.last),
    .i_out_digit (o_out.digit)
);

[tb/sv/tb_binary_to_radix_digits.sv]
// Self-checking testbench for the binary to radix digit converter.
`timescale 1ns / 1ps

module tb_binary_to_radix_digits;
    import btrd_pkg::*;

    localparam longint unsigned VALUE_MASK  = (64'd1 << VALUE_BITS) - 1;
    localparam int unsigned     REG_UNUSED  = 1;
    localparam int unsigned     DRAIN_PAD   = 16;
    localparam int unsigned     PHASES      = 8;
    localparam int unsigned     PHASE_ITEMS = 36;
    localparam int unsigned     CYCLE_LIMIT = 1000000;

    typedef struct {
        t_digit digit;
        logic   last;
    } t_digit_result;

    class digit_scoreboard;
        t_base         base_reg;
        t_digit_result expected_digits[$];
        int            errors;

        function new();
            base_reg = BASE_RESET;
            errors   = 0;
        endfunction

        function void set_base(t_base b);
            base_reg = b;
        endfunction

        // Clamp the register to the supported range of bases.
        function int unsigned radix();
            int unsigned r;
            r = base_reg;
            if (r < BASE_MIN) r = BASE_MIN;
            if (r > BASE_MAX) r = BASE_MAX;
            return r;
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction

        function void mismatch(string msg);
            errors++;
            if (errors <= 10) $display("%0t ns: %s", $time, msg);
        endfunction

        function void note_value(t_value v);
            int unsigned     digits[$];
            longint unsigned rest;
            int unsigned     r;
            t_digit_result   e;
            r    = radix();
            rest = v;
            // Peel digits off the low end; push_front leaves the most significant first.
            do begin
                digits.push_front(int'(rest % r));
                rest = rest / r;
            end while (rest != 0);
            foreach (digits[k]) begin
                e.digit = t_digit'(digits[k]);
                e.last  = (k == digits.size() - 1);
                expected_digits.push_back(e);
            end
        endfunction

        function void check_digit(t_digit d, logic l);
            t_digit_result e;
            if (expected_digits.size() == 0) begin
                mismatch($sformatf("unexpected digit %0d last %0b", d, l));
                return;
            end
            e = expected_digits.pop_front();
            if (d !== e.digit || l !== e.last)
                mismatch($sformatf("digit expected %0d last %0b, got %0d last %0b",
                                   e.digit, e.last, d, l));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    btrd_in_if  in_ch ();
    btrd_out_if out_ch ();

    digit_scoreboard sb = new();

    int unsigned rx_hold_cycles = 0;
    bit          rx_steady      = 1'b0;
    bit          tx_steady      = 1'b0;
    int unsigned cycle_count    = 0;

    binary_to_radix_digits dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("binary_to_radix_digits test failed");
            $finish;
        end
    end

    // Check results before noting the request taken at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (out_ch.valid && out_ch.ready) sb.check_digit(out_ch.digit, out_ch.last);
            if (in_ch.valid && in_ch.ready) sb.note_value(in_ch.value);
        end
    end

    function automatic int unsigned pause_length();
        if ($urandom_range(0, 7) == 0) return $urandom_range(8, 24);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_value pick_value(int unsigned r);
        longint unsigned p;
        int unsigned     k;
        p = 1;
        case ($urandom_range(0, 3))
            0: return t_value'($urandom);
            1: return t_value'($urandom_range(0, 255));
            2: return t_value'($urandom >> $urandom_range(1, 31));
            default: begin
                // Land on or next to a power of the base.
                k = $urandom_range(1, 31);
                repeat (k) if (p * r <= VALUE_MASK) p = p * r;
                return t_value'(p - 1 + $urandom_range(0, 2));
            end
        endcase
    endfunction

    // Result side: mostly ready, random stalls, plus a long hold on request.
    initial begin : result_sink
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end else if (rx_steady || $urandom_range(0, 3) != 0) begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b0;
                repeat (pause_length()) @(posedge i_clk);
            end
        end
    end

    // Hold the request until it is taken; leave valid high for a following request.
    task automatic send_value(input t_value v);
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic offer(input t_value v);
        send_value(v);
        if (!tx_steady && $urandom_range(0, 2) == 0) begin
            in_ch.valid <= 1'b0;
            repeat (pause_length()) @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Write one register, then read the base back where it is the target.
    task automatic set_register(input int unsigned index, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (index == int'(REG_BASE)) begin
            sb.set_base(data[BASE_W-1:0]);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata[BASE_W-1:0] !== sb.base_reg)
                sb.mismatch($sformatf("base read back %0d, expected %0d",
                                      prdata[BASE_W-1:0], sb.base_reg));
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        int unsigned phase_bases[PHASES] = '{10, 2, 16, 0, 31, 7, 0, 0};
        int unsigned b;

        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset base: zero, digit boundaries, top value and bit patterns.
        offer(0);
        offer(1);
        offer(9);
        offer(10);
        offer(99);
        offer(100);
        offer(999999999);
        offer(1000000000);
        offer(t_value'(VALUE_MASK));
        offer(t_value'(32'h2AAA_AAAA));
        offer(t_value'(32'h5555_5555));
        settle();

        // Base 2 gives the longest digit strings.
        set_register(REG_BASE, 2);
        offer(0);
        offer(1);
        offer(t_value'(VALUE_MASK));
        offer(t_value'(32'h4000_0000));
        settle();

        set_register(REG_BASE, 16);
        offer(15);
        offer(16);
        offer(t_value'(VALUE_MASK));
        settle();

        // Bases below two saturate to two, above sixteen to sixteen.
        set_register(REG_BASE, 0);
        offer(6);
        settle();
        set_register(REG_BASE, 1);
        offer(5);
        settle();
        set_register(REG_BASE, 17);
        offer(255);
        settle();
        set_register(REG_BASE, 31);
        offer(256);
        settle();

        // Write to an unused index: the base must stay as it was.
        set_register(REG_UNUSED, 3);
        offer(4096);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            b = (ph >= 6) ? $urandom_range(0, 31) : phase_bases[ph];
            set_register(REG_BASE, b);
            rx_steady = (ph == 5);
            tx_steady = (ph == 5);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Stall the result side long enough to back up the request side.
                if (ph == 2 && i == 4) rx_hold_cycles = 400;
                if (ph == 1 && i == 20) wait_results();
                offer(pick_value(sb.radix()));
            end
            settle();
        end
        rx_steady = 1'b0;
        tx_steady = 1'b0;

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("binary_to_radix_digits test passed");
        end else begin
            $display("binary_to_radix_digits test failed");
        end
        $finish;
    end

endmodule

[sim.f]
sv/btrd_pkg.sv
sv/btrd_in_if.sv
sv/btrd_out_if.sv
sv/btrd_ctrl.sv
sv/btrd_dp.sv
sv/binary_to_radix_digits.sv
sv/btrd_checker.sv
tb/sv/tb_binary_to_radix_digits.sv
